>>> rtl/dwsd_pkg.sv
// ----------------------------------------------------------------------------
// dwsd_pkg
// shared types and constants of the digitizer word stream decoder
// ----------------------------------------------------------------------------
package dwsd_pkg;

    localparam int PAYLOAD_W = 48;
    localparam int COUNTER_W = 40;
    localparam int SAMPLE_W  = 12;
    localparam int COUNT_W   = 15;
    localparam int PULSE_W   = 32;
    localparam int CFG_DATA_W = 15;

    // register indexes
    localparam logic [0:0] REG_NUM_CHANNELS = 1'b0;
    localparam logic [0:0] REG_MAX_SAMPLES  = 1'b1;

    localparam logic [7:0]  NUM_CHANNELS_RST = 8'd32;
    localparam logic [14:0] MAX_SAMPLES_RST  = 15'd32763;
    localparam logic [14:0] SAMPLE_CAP       = 15'd32763;
    localparam logic [14:0] SAMPLE_STEP      = 15'd4;

    // record formats
    localparam logic [3:0] FMT_START   = 4'd0;
    localparam logic [3:0] FMT_COUNTER = 4'd1;
    localparam logic [3:0] FMT_SAMPLES = 4'd2;

    // result kinds
    localparam logic [2:0] KIND_START    = 3'd0;
    localparam logic [2:0] KIND_COUNTER  = 3'd1;
    localparam logic [2:0] KIND_SAMPLES  = 3'd2;
    localparam logic [2:0] KIND_BAD_CHAN = 3'd3;
    localparam logic [2:0] KIND_OVERFLOW = 3'd4;
    localparam logic [2:0] KIND_IGNORED  = 3'd5;

    typedef struct packed {
        logic [PAYLOAD_W-1:0] payload;
        logic [7:0]           control_byte;
        logic [7:0]           format_byte;
        logic [7:0]           channel;
    } rec_t;

    typedef struct packed {
        logic [2:0]                  kind;
        logic [7:0]                  pulse_channel;
        logic [PULSE_W-1:0]          pulse_number;
        logic [PAYLOAD_W-1:0]        timestamp;
        logic [COUNTER_W-1:0]        event_counter;
        logic [7:0]                  control_value;
        logic signed [SAMPLE_W-1:0]  sample_a;
        logic signed [SAMPLE_W-1:0]  sample_b;
        logic signed [SAMPLE_W-1:0]  sample_c;
        logic signed [SAMPLE_W-1:0]  sample_d;
        logic [COUNT_W-1:0]          sample_index;
    } res_t;

    typedef struct packed {
        logic       we;
        logic [0:0] index;
        logic [CFG_DATA_W-1:0] data;
    } cfg_wr_t;

endpackage

>>> rtl/dwsd_if.sv
// ----------------------------------------------------------------------------
// dwsd_if
// record and result channels with valid/ready handshake
// ----------------------------------------------------------------------------
interface dwsd_rec_if;
    logic        valid;
    logic        ready;
    logic [47:0] payload;
    logic [7:0]  control_byte;
    logic [7:0]  format_byte;
    logic [7:0]  channel;

    modport source (output valid, output payload, output control_byte,
                    output format_byte, output channel, input ready);
    modport sink   (input valid, input payload, input control_byte,
                    input format_byte, input channel, output ready);
endinterface

interface dwsd_res_if;
    logic               valid;
    logic               ready;
    logic [2:0]         kind;
    logic [7:0]         pulse_channel;
    logic [31:0]        pulse_number;
    logic [47:0]        timestamp;
    logic [39:0]        event_counter;
    logic [7:0]         control_value;
    logic signed [11:0] sample_a;
    logic signed [11:0] sample_b;
    logic signed [11:0] sample_c;
    logic signed [11:0] sample_d;
    logic [14:0]        sample_index;

    modport source (output valid, output kind, output pulse_channel,
                    output pulse_number, output timestamp, output event_counter,
                    output control_value, output sample_a, output sample_b,
                    output sample_c, output sample_d, output sample_index,
                    input ready);
    modport sink   (input valid, input kind, input pulse_channel,
                    input pulse_number, input timestamp, input event_counter,
                    input control_value, input sample_a, input sample_b,
                    input sample_c, input sample_d, input sample_index,
                    output ready);
endinterface

>>> rtl/dwsd_in_reg.sv
// ----------------------------------------------------------------------------
// dwsd_in_reg
// input register holding one record in front of the decode logic
// ----------------------------------------------------------------------------
module dwsd_in_reg
(
    input  logic              clk,
    input  logic              rst_n,
    dwsd_rec_if.sink          rx,
    input  logic              advance,
    output logic              valid,
    output dwsd_pkg::rec_t    rec
);

    logic           valid_reg;
    logic           valid_next;
    dwsd_pkg::rec_t rec_reg;
    logic           take;

    assign rx.ready   = !valid_reg || advance;
    assign take       = rx.valid && rx.ready;
    assign valid_next = take ? 1'b1 : (advance ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            rec_reg.payload      <= rx.payload;
            rec_reg.control_byte <= rx.control_byte;
            rec_reg.format_byte  <= rx.format_byte;
            rec_reg.channel      <= rx.channel;
        end
    end

    assign valid = valid_reg;
    assign rec   = rec_reg;

endmodule

>>> rtl/dwsd_core.sv
// ----------------------------------------------------------------------------
// dwsd_core
// pulse state, configuration registers and record decode
// ----------------------------------------------------------------------------
module dwsd_core
(
    input  logic              clk,
    input  logic              rst_n,
    input  dwsd_pkg::cfg_wr_t cfg,
    input  logic              advance,
    input  dwsd_pkg::rec_t    rec,
    output dwsd_pkg::res_t    res
);

    logic [7:0]  num_channels_reg;
    logic [14:0] max_samples_reg;

    logic [7:0]  current_channel_reg;
    logic [7:0]  current_channel_next;
    logic        first_seen_reg;
    logic [14:0] sample_count_reg;
    logic [14:0] sample_count_next;
    logic [31:0] pulse_index_reg;
    logic [31:0] pulse_index_next;

    logic        is_first;
    logic [3:0]  fmt;
    logic [7:0]  chan_eff;
    logic [14:0] count_eff;
    logic [31:0] pulse_eff;
    logic [14:0] limit;
    logic        bad;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_channels_reg <= dwsd_pkg::NUM_CHANNELS_RST;
            max_samples_reg  <= dwsd_pkg::MAX_SAMPLES_RST;
        end
        else if (cfg.we)
        begin
            case (cfg.index)
                dwsd_pkg::REG_NUM_CHANNELS: num_channels_reg <= cfg.data[7:0];
                dwsd_pkg::REG_MAX_SAMPLES:  max_samples_reg  <= cfg.data[14:0];
                default: ;
            endcase
        end
    end

    assign is_first  = !first_seen_reg;
    assign fmt       = rec.format_byte[7:4];
    assign chan_eff  = is_first ? rec.channel : current_channel_reg;
    assign count_eff = is_first ? 15'd0 : sample_count_reg;
    assign pulse_eff = is_first ? 32'd1 : pulse_index_reg;
    assign limit     = (max_samples_reg > dwsd_pkg::SAMPLE_CAP) ? dwsd_pkg::SAMPLE_CAP
                                                                : max_samples_reg;
    assign bad       = (rec.channel >= num_channels_reg)
                    || ((fmt != dwsd_pkg::FMT_START) && (rec.channel != chan_eff));

    always_comb
    begin
        current_channel_next = chan_eff;
        sample_count_next    = count_eff;
        pulse_index_next     = pulse_eff;
        res                  = '0;
        if (bad)
        begin
            res.kind = dwsd_pkg::KIND_BAD_CHAN;
        end
        else
        begin
            case (fmt)
                dwsd_pkg::FMT_START:
                begin
                    if (!is_first)
                    begin
                        pulse_index_next  = pulse_index_reg + 32'd1;
                        sample_count_next = 15'd0;
                    end
                    current_channel_next = rec.channel;
                    res.kind             = dwsd_pkg::KIND_START;
                    res.timestamp        = rec.payload;
                end
                dwsd_pkg::FMT_COUNTER:
                begin
                    res.kind          = dwsd_pkg::KIND_COUNTER;
                    res.event_counter = rec.payload[39:0];
                    res.control_value = rec.control_byte + 8'd1;
                end
                dwsd_pkg::FMT_SAMPLES:
                begin
                    if (count_eff >= limit)
                    begin
                        res.kind = dwsd_pkg::KIND_OVERFLOW;
                    end
                    else
                    begin
                        res.kind          = dwsd_pkg::KIND_SAMPLES;
                        res.sample_a      = $signed(rec.payload[11:0]);
                        res.sample_b      = $signed(rec.payload[23:12]);
                        res.sample_c      = $signed(rec.payload[35:24]);
                        res.sample_d      = $signed(rec.payload[47:36]);
                        res.sample_index  = count_eff;
                        sample_count_next = count_eff + dwsd_pkg::SAMPLE_STEP;
                    end
                end
                default:
                begin
                    res.kind = dwsd_pkg::KIND_IGNORED;
                end
            endcase
        end
        res.pulse_channel = current_channel_next;
        res.pulse_number  = pulse_index_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            current_channel_reg <= 8'd0;
            first_seen_reg      <= 1'b0;
            sample_count_reg    <= 15'd0;
            pulse_index_reg     <= 32'd0;
        end
        else if (advance)
        begin
            current_channel_reg <= current_channel_next;
            first_seen_reg      <= 1'b1;
            sample_count_reg    <= sample_count_next;
            pulse_index_reg     <= pulse_index_next;
        end
    end

endmodule

>>> rtl/dwsd_out_reg.sv
// ----------------------------------------------------------------------------
// dwsd_out_reg
// result register driving the result channel
// ----------------------------------------------------------------------------
module dwsd_out_reg
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           advance,
    input  dwsd_pkg::res_t res,
    output logic           room,
    dwsd_res_if.source     tx
);

    logic           valid_reg;
    logic           valid_next;
    dwsd_pkg::res_t res_reg;

    assign room       = !valid_reg || tx.ready;
    assign valid_next = advance ? 1'b1 : (tx.ready ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg <= res;
        end
    end

    assign tx.valid         = valid_reg;
    assign tx.kind          = res_reg.kind;
    assign tx.pulse_channel = res_reg.pulse_channel;
    assign tx.pulse_number  = res_reg.pulse_number;
    assign tx.timestamp     = res_reg.timestamp;
    assign tx.event_counter = res_reg.event_counter;
    assign tx.control_value = res_reg.control_value;
    assign tx.sample_a      = res_reg.sample_a;
    assign tx.sample_b      = res_reg.sample_b;
    assign tx.sample_c      = res_reg.sample_c;
    assign tx.sample_d      = res_reg.sample_d;
    assign tx.sample_index  = res_reg.sample_index;

endmodule

>>> rtl/digitizer_word_stream_decoder.sv
// path: a record is held in the input register, decoded, and its result registered onto tx
// throughput: one record per cycle while tx does not stall, set by the single
//   decode step between input and result register, which also updates the pulse state
// reset: rst_n asynchronous active low clears the pulse state and both stages,
//   and loads num_channels = 32 and max_samples = 32763
// ----------------------------------------------------------------------------
// digitizer_word_stream_decoder
// decodes 72-bit digitizer records into pulse start, counter and sample results
// ----------------------------------------------------------------------------
module digitizer_word_stream_decoder
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [14:0] cfg_data,
    dwsd_rec_if.sink    rx,
    dwsd_res_if.source  tx
);

    logic              rec_valid;
    dwsd_pkg::rec_t    rec;
    dwsd_pkg::res_t    res;
    dwsd_pkg::cfg_wr_t cfg;
    logic              room;
    logic              advance;

    assign cfg.we    = cfg_we;
    assign cfg.index = cfg_index;
    assign cfg.data  = cfg_data;
    assign advance   = rec_valid && room;

    dwsd_in_reg u_in_reg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .rx      (rx),
        .advance (advance),
        .valid   (rec_valid),
        .rec     (rec)
    );

    dwsd_core u_core
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .advance (advance),
        .rec     (rec),
        .res     (res)
    );

    dwsd_out_reg u_out_reg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .res     (res),
        .room    (room),
        .tx      (tx)
    );

`ifndef SYNTH
    a_advance_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> tx.valid)
        else $error("decoded transaction did not reach the result register");

    a_sample_index_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        (tx.valid && tx.kind == dwsd_pkg::KIND_SAMPLES) |-> (tx.sample_index[1:0] == 2'd0))
        else $error("sample index not a multiple of four");

    a_ready_when_draining: assert property (@(posedge clk) disable iff (!rst_n)
        (rec_valid && room) |-> rx.ready)
        else $error("input not ready while the held record moves on");
`endif

endmodule

>>> test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the digitizer word stream decoder. Records go in
// over the rx channel and results come out of the tx channel. Both sides
// idle and stall at random. A scoreboard keeps its own copy of the pulse
// state and of the two registers, works out the result of every accepted
// record and compares each result field by field, in order. The stimulus
// has these parts:
//   - a directed part: the first record of the stream, the field extremes,
//     every format and the bad-channel rules
//   - several register settings, among them zero channels, a zero sample
//     limit and at random a limit above the cap, each with random pulses
//   - one pulse with the limit written above the cap
// ----------------------------------------------------------------------------
module tb_top;

    localparam int WATCHDOG_LIMIT     = 200;
    localparam int DRAIN_CYCLES       = 4;
    localparam int MAX_PRINTED        = 100;
    localparam int LONG_PULSE_RECORDS = 20;

    localparam logic [3:0] FMT_IGNORED_LO = 4'd3;
    localparam logic [3:0] FMT_IGNORED_HI = 4'd15;

    class pulse_scoreboard;
        logic [7:0]         chan_limit;
        logic [14:0]        sample_limit;
        logic [7:0]         pulse_chan;
        logic               stream_open;
        logic [14:0]        samples_held;
        logic [31:0]        pulse_no;
        dwsd_pkg::res_t     awaited_results[$];
        int                 errors;
        int                 n_checked;

        function new();
            chan_limit   = dwsd_pkg::NUM_CHANNELS_RST;
            sample_limit = dwsd_pkg::MAX_SAMPLES_RST;
            pulse_chan   = '0;
            stream_open  = 1'b0;
            samples_held = '0;
            pulse_no     = '0;
            errors       = 0;
            n_checked    = 0;
        endfunction

        function void set_register(logic [0:0] idx, logic [14:0] data);
            if (idx == dwsd_pkg::REG_NUM_CHANNELS)
                chan_limit = data[7:0];
            else
                sample_limit = data;
        endfunction

        function int pending();
            return awaited_results.size();
        endfunction

        function dwsd_pkg::res_t decode_record(dwsd_pkg::rec_t r);
            dwsd_pkg::res_t e;
            logic [3:0]     fmt;
            logic           first;
            logic [14:0]    lim;
            e     = '0;
            fmt   = r.format_byte[7:4];
            first = !stream_open;
            // the first record of the stream opens pulse one on its own channel
            if (first)
            begin
                stream_open  = 1'b1;
                pulse_no     = 32'd1;
                pulse_chan   = r.channel;
                samples_held = '0;
            end
            if (r.channel >= chan_limit
                || (fmt != dwsd_pkg::FMT_START && r.channel != pulse_chan))
                e.kind = dwsd_pkg::KIND_BAD_CHAN;
            else if (fmt == dwsd_pkg::FMT_START)
            begin
                if (!first)
                begin
                    pulse_no     = pulse_no + 32'd1;
                    samples_held = '0;
                end
                pulse_chan  = r.channel;
                e.kind      = dwsd_pkg::KIND_START;
                e.timestamp = r.payload;
            end
            else if (fmt == dwsd_pkg::FMT_COUNTER)
            begin
                e.kind          = dwsd_pkg::KIND_COUNTER;
                e.event_counter = r.payload[39:0];
                e.control_value = r.control_byte + 8'd1;
            end
            else if (fmt == dwsd_pkg::FMT_SAMPLES)
            begin
                lim = (sample_limit > dwsd_pkg::SAMPLE_CAP) ? dwsd_pkg::SAMPLE_CAP
                                                            : sample_limit;
                if (samples_held >= lim)
                    e.kind = dwsd_pkg::KIND_OVERFLOW;
                else
                begin
                    e.kind         = dwsd_pkg::KIND_SAMPLES;
                    e.sample_a     = r.payload[11:0];
                    e.sample_b     = r.payload[23:12];
                    e.sample_c     = r.payload[35:24];
                    e.sample_d     = r.payload[47:36];
                    e.sample_index = samples_held;
                    samples_held   = samples_held + dwsd_pkg::SAMPLE_STEP;
                end
            end
            else
                e.kind = dwsd_pkg::KIND_IGNORED;
            e.pulse_channel = pulse_chan;
            e.pulse_number  = pulse_no;
            return e;
        endfunction

        function void note_record(dwsd_pkg::rec_t r);
            awaited_results = {awaited_results, decode_record(r)};
        endfunction

        task report(string msg);
            if (errors < MAX_PRINTED)
                $display("mismatch: %s", msg);
            errors++;
        endtask

        task compare(string name, logic [63:0] got, logic [63:0] want);
            if (got !== want)
                report($sformatf("result %0d %s: got %0h, expected %0h",
                                 n_checked, name, got, want));
        endtask

        task check_result(dwsd_pkg::res_t got);
            dwsd_pkg::res_t want;
            if (awaited_results.size() == 0)
            begin
                report($sformatf("result %0d arrived with none outstanding", n_checked));
                n_checked++;
                return;
            end
            want = awaited_results.pop_front();
            compare("kind", got.kind, want.kind);
            compare("pulse_channel", got.pulse_channel, want.pulse_channel);
            compare("pulse_number", got.pulse_number, want.pulse_number);
            compare("timestamp", got.timestamp, want.timestamp);
            compare("event_counter", got.event_counter, want.event_counter);
            compare("control_value", got.control_value, want.control_value);
            compare("sample_a", got.sample_a, want.sample_a);
            compare("sample_b", got.sample_b, want.sample_b);
            compare("sample_c", got.sample_c, want.sample_c);
            compare("sample_d", got.sample_d, want.sample_d);
            compare("sample_index", got.sample_index, want.sample_index);
            n_checked++;
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [0:0]  cfg_index;
    logic [14:0] cfg_data;

    dwsd_rec_if rx();
    dwsd_res_if tx();

    digitizer_word_stream_decoder u_top
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .rx        (rx),
        .tx        (tx)
    );

    pulse_scoreboard sb = new();
    bit              src_idle_on;
    bit              snk_idle_on;
    int              records_sent;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function logic [47:0] rand_payload();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            2: return 48'h800800800800;
            3: return 48'h7FF7FF7FF7FF;
            default: return {16'($urandom), $urandom};
        endcase
    endfunction

    task send_record(dwsd_pkg::rec_t r);
        int gap;
        if ($urandom_range(0, 31) == 0)
            src_idle_on = !src_idle_on;
        gap = src_idle_on ? $urandom_range(0, 6) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            rx.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        rx.valid        <= 1'b1;
        rx.payload      <= r.payload;
        rx.control_byte <= r.control_byte;
        rx.format_byte  <= r.format_byte;
        rx.channel      <= r.channel;
        do
            @(posedge clk);
        while (!rx.ready);
        sb.note_record(r);
        records_sent++;
    endtask

    task send_fields(logic [3:0] fmt, logic [3:0] low_nibble, logic [7:0] ch,
                     logic [47:0] pl, logic [7:0] ctrl);
        dwsd_pkg::rec_t r;
        r.payload      = pl;
        r.control_byte = ctrl;
        r.format_byte  = {fmt, low_nibble};
        r.channel      = ch;
        send_record(r);
    endtask

    // stop sending and let every outstanding result come out
    task drain();
        @(negedge clk);
        rx.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task write_register(logic [0:0] idx, logic [14:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_we    <= 1'b0;
        sb.set_register(idx, data);
    endtask

    task set_mode(logic [7:0] n_chan, logic [14:0] n_samples);
        drain();
        write_register(dwsd_pkg::REG_NUM_CHANNELS, {7'($urandom), n_chan});
        write_register(dwsd_pkg::REG_MAX_SAMPLES, n_samples);
    endtask

    // pulses on one channel each, with noise and foreign channels mixed in
    task random_stream(int n);
        int         target;
        int         len;
        int         p;
        logic [7:0] ch;
        logic [3:0] f;
        target = records_sent + n;
        while (records_sent < target)
        begin
            if (sb.chan_limit == 0 || $urandom_range(0, 9) == 0)
                ch = 8'($urandom);
            else
                ch = 8'($urandom_range(0, sb.chan_limit - 1));
            send_fields(dwsd_pkg::FMT_START, 4'($urandom), ch, rand_payload(),
                        8'($urandom));
            len = $urandom_range(0, 12);
            repeat (len)
            begin
                p = $urandom_range(0, 99);
                if (p < 45)
                    f = dwsd_pkg::FMT_SAMPLES;
                else if (p < 75)
                    f = dwsd_pkg::FMT_COUNTER;
                else
                    f = 4'($urandom_range(FMT_IGNORED_LO, FMT_IGNORED_HI));
                if (p < 83)
                    send_fields(f, 4'($urandom), ch, rand_payload(), 8'($urandom));
                else if (p < 93)
                    send_fields(4'($urandom), 4'($urandom), ch + 8'($urandom_range(1, 255)),
                                rand_payload(), 8'($urandom));
                else
                    send_fields(4'($urandom), 4'($urandom), 8'($urandom),
                                rand_payload(), 8'($urandom));
            end
        end
    endtask

    // result side
    initial
    begin
        dwsd_pkg::res_t got;
        int             stall;
        tx.ready    = 1'b0;
        snk_idle_on = 1'b1;
        wait (rst_n === 1'b1);
        forever
        begin
            if ($urandom_range(0, 31) == 0)
                snk_idle_on = !snk_idle_on;
            stall = snk_idle_on ? $urandom_range(0, 6) : 0;
            @(negedge clk);
            if (stall > 0)
            begin
                tx.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            tx.ready <= 1'b1;
            do
                @(posedge clk);
            while (!tx.valid);
            got.kind          = tx.kind;
            got.pulse_channel = tx.pulse_channel;
            got.pulse_number  = tx.pulse_number;
            got.timestamp     = tx.timestamp;
            got.event_counter = tx.event_counter;
            got.control_value = tx.control_value;
            got.sample_a      = tx.sample_a;
            got.sample_b      = tx.sample_b;
            got.sample_c      = tx.sample_c;
            got.sample_d      = tx.sample_d;
            got.sample_index  = tx.sample_index;
            sb.check_result(got);
        end
    end

    // watchdog on cycles without any transaction
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((rx.valid && rx.ready) || (tx.valid && tx.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("FAIL");
        $finish;
    end

    // stimulus
    initial
    begin
        logic [7:0]  ch;
        logic [3:0]  first_fmt;
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = dwsd_pkg::REG_NUM_CHANNELS;
        cfg_data        = '0;
        rx.valid        = 1'b0;
        rx.payload      = '0;
        rx.control_byte = '0;
        rx.format_byte  = '0;
        rx.channel      = '0;
        src_idle_on     = 1'b1;
        records_sent    = 0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // first record of the stream, any format and any channel
        case ($urandom_range(0, 3))
            0: first_fmt = dwsd_pkg::FMT_START;
            1: first_fmt = dwsd_pkg::FMT_COUNTER;
            2: first_fmt = dwsd_pkg::FMT_SAMPLES;
            default: first_fmt = FMT_IGNORED_HI;
        endcase
        send_fields(first_fmt, 4'($urandom), 8'($urandom), rand_payload(), 8'($urandom));

        send_fields(dwsd_pkg::FMT_START, 4'h0, 8'd0, '0, 8'd0);
        send_fields(dwsd_pkg::FMT_COUNTER, 4'hF, 8'd0, '1, 8'hFF);
        send_fields(dwsd_pkg::FMT_COUNTER, 4'h0, 8'd0, '0, 8'h00);
        send_fields(dwsd_pkg::FMT_SAMPLES, 4'h0, 8'd0, 48'h800800800800, 8'h00);
        send_fields(dwsd_pkg::FMT_SAMPLES, 4'hA, 8'd0, 48'h7FF7FF7FF7FF, 8'hFF);
        send_fields(dwsd_pkg::FMT_SAMPLES, 4'h5, 8'd0, '1, 8'h55);
        send_fields(dwsd_pkg::FMT_SAMPLES, 4'h0, 8'd0, '0, 8'hAA);
        send_fields(FMT_IGNORED_LO, 4'h0, 8'd0, '1, 8'h00);
        send_fields(FMT_IGNORED_HI, 4'hF, 8'd0, '1, 8'hFF);
        // foreign channel and channels at or above the limit
        send_fields(dwsd_pkg::FMT_COUNTER, 4'h0, 8'd5, '1, 8'h12);
        send_fields(dwsd_pkg::FMT_SAMPLES, 4'h0, 8'd31, '1, 8'h00);
        send_fields(dwsd_pkg::FMT_START, 4'h0, 8'd32, '1, 8'h00);
        send_fields(dwsd_pkg::FMT_START, 4'hF, 8'd255, '1, 8'hFF);
        send_fields(dwsd_pkg::FMT_START, 4'h3, 8'd31, '1, 8'h00);
        send_fields(dwsd_pkg::FMT_COUNTER, 4'h0, 8'd31, 48'h123456789ABC, 8'h7F);
        send_fields(dwsd_pkg::FMT_START, 4'hF, 8'd31, 48'hA5A5A5A5A5A5, 8'h00);
        send_fields(FMT_IGNORED_HI, 4'h5, 8'd0, '0, 8'h00);
        send_fields(dwsd_pkg::FMT_START, 4'h5, 8'd16, 48'h5A5A5A5A5A5A, 8'h00);
        send_fields(dwsd_pkg::FMT_SAMPLES, 4'h0, 8'd16, 48'h000FFF000FFF, 8'h00);

        // one channel, sample limit 4: one sample record per pulse
        set_mode(8'd1, 15'd4);
        send_fields(dwsd_pkg::FMT_START, 4'h0, 8'd0, rand_payload(), 8'($urandom));
        send_fields(dwsd_pkg::FMT_SAMPLES, 4'h0, 8'd0, rand_payload(), 8'($urandom));
        send_fields(dwsd_pkg::FMT_SAMPLES, 4'h0, 8'd0, rand_payload(), 8'($urandom));
        send_fields(dwsd_pkg::FMT_START, 4'h0, 8'd0, rand_payload(), 8'($urandom));
        send_fields(dwsd_pkg::FMT_SAMPLES, 4'h0, 8'd0, rand_payload(), 8'($urandom));
        send_fields(dwsd_pkg::FMT_START, 4'h0, 8'd1, rand_payload(), 8'($urandom));
        random_stream(60);

        // no channels at all
        set_mode(8'd0, 15'd0);
        random_stream(25);

        // channels 0 to 254, every sample record refused
        set_mode(8'd255, 15'd0);
        send_fields(dwsd_pkg::FMT_START, 4'h0, 8'd254, rand_payload(), 8'($urandom));
        send_fields(dwsd_pkg::FMT_SAMPLES, 4'h0, 8'd254, rand_payload(), 8'($urandom));
        random_stream(60);

        repeat (4)
        begin
            if ($urandom_range(0, 3) == 0)
                set_mode(8'($urandom_range(1, 255)), 15'($urandom_range(32763, 32767)));
            else
                set_mode(8'($urandom_range(1, 255)), 15'($urandom_range(0, 80)));
            random_stream(65);
        end
        set_mode(dwsd_pkg::NUM_CHANNELS_RST, dwsd_pkg::MAX_SAMPLES_RST);
        random_stream(60);

        // one pulse with the limit written above the cap
        set_mode(8'd255, 15'h7FFF);
        ch = 8'($urandom_range(0, 254));
        send_fields(dwsd_pkg::FMT_START, 4'($urandom), ch, rand_payload(), 8'($urandom));
        repeat (LONG_PULSE_RECORDS)
            send_fields(dwsd_pkg::FMT_SAMPLES, 4'($urandom), ch, rand_payload(),
                        8'($urandom));

        drain();
        if (sb.errors == 0 && sb.pending() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

>>> sim.f
rtl/dwsd_pkg.sv
rtl/dwsd_if.sv
rtl/dwsd_in_reg.sv
rtl/dwsd_core.sv
rtl/dwsd_out_reg.sv
rtl/digitizer_word_stream_decoder.sv
test/tb_top.sv
